[rtl/assert_macros.svh]
// Assertion macros for the RTL of the deadband report block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed in deadband report block");

// A condition that must never be seen outside of reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition in deadband report block");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[rtl/dbh_pkg.sv]
// Constants and widths for the deadband report block with heartbeat.
package dbh_pkg;

  localparam int TEMP_W     = 15;
  localparam int HUM_W      = 7;
  localparam int TIME_W     = 32;
  localparam int TTHR_W     = 10;
  localparam int HTHR_W     = 6;
  localparam int HBS_W      = 10;
  localparam int HB_MS_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  localparam logic [HBS_W-1:0] MS_PER_SECOND = 10'd1000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DEADBAND     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_DEADBAND      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_SECONDS = 2'd2;

  // Reset values.
  localparam logic [TTHR_W-1:0]        TEMP_DEADBAND_RST = 10'd50;
  localparam logic [HTHR_W-1:0]        HUM_DEADBAND_RST  = 6'd3;
  localparam logic [HB_MS_W-1:0]       HEARTBEAT_MS_RST  = 20'd45000;
  localparam logic signed [TEMP_W-1:0] TEMP_START        = 15'sd2500;
  localparam logic [HUM_W-1:0]         HUM_START         = 7'd60;

endpackage

[rtl/deadband_report_with_heartbeat.sv]
// Deadband report-by-exception filter with a heartbeat timeout.
//
//  channel | direction | payload                                   | handshake
//  --------+-----------+-------------------------------------------+------------------
//  s_axis  | in        | temperature, humidity, now_ms (56b tdata) | tvalid / tready
//  m_axis  | out       | report flags and reported values (24b),   | tvalid / tready
//          |           | heartbeat flag in tuser                   |
//  cfg     | in        | register index and 10-bit value           | valid / ready
//
// One sample per cycle while each result is taken, set by the single
// compare-and-update on the stored values. A sample waits in the input register
// and its result loads into the output register once that is free or emptied.
// Reset is synchronous and active high; it restores the thresholds, the start
// values and a zero reference time. A result that is not taken holds the output
// register; the input register then keeps its sample and the input side stalls.
`include "assert_macros.svh"

module deadband_report_with_heartbeat (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [14:0] temperature, [21:15] humidity, [53:22] now_ms, [55:54] zero
  input  logic [dbh_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] report_temperature, [1] report_humidity,
  // [16:2] reported_temperature, [23:17] reported_humidity
  output logic [dbh_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] is_heartbeat
  output logic                             m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dbh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dbh_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import dbh_pkg::*;

  // Configuration. The heartbeat period is kept in milliseconds, converted
  // once when the register is written.
  logic [TTHR_W-1:0]  temp_deadband;
  logic [HTHR_W-1:0]  hum_deadband;
  logic [HB_MS_W-1:0] heartbeat_ms;

  // Reference state: last reported values and the time of the last report.
  logic signed [TEMP_W-1:0] last_temperature;
  logic [HUM_W-1:0]         last_humidity;
  logic [TIME_W-1:0]        last_report_time;

  // Input register.
  logic                     s1_valid;
  logic signed [TEMP_W-1:0] s1_temperature;
  logic [HUM_W-1:0]         s1_humidity;
  logic [TIME_W-1:0]        s1_now;

  // Output register.
  logic                     out_valid;
  logic                     out_report_temperature;
  logic                     out_report_humidity;
  logic                     out_is_heartbeat;
  logic signed [TEMP_W-1:0] out_reported_temperature;
  logic [HUM_W-1:0]         out_reported_humidity;

  // Evaluation of the sample held in the input register.
  logic                     advance;
  logic signed [TEMP_W:0]   temp_diff;
  logic [TEMP_W:0]          temp_mag;
  logic signed [HUM_W:0]    hum_diff;
  logic [HUM_W:0]           hum_mag;
  logic [TIME_W-1:0]        since;
  logic                     temp_over;
  logic                     hum_over;
  logic                     beat;
  logic                     rep_t;
  logic                     rep_h;
  logic signed [TEMP_W-1:0] last_temperature_next;
  logic [HUM_W-1:0]         last_humidity_next;

  // The input register moves on whenever the output register is free or
  // is being emptied in this cycle.
  assign advance       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign cfg_ready     = 1'b1;

  always_comb begin
    temp_diff = {s1_temperature[TEMP_W-1], s1_temperature}
              - {last_temperature[TEMP_W-1], last_temperature};
    temp_mag  = temp_diff[TEMP_W] ? (TEMP_W+1)'(-temp_diff) : (TEMP_W+1)'(temp_diff);
    hum_diff  = {1'b0, s1_humidity} - {1'b0, last_humidity};
    hum_mag   = hum_diff[HUM_W] ? (HUM_W+1)'(-hum_diff) : (HUM_W+1)'(hum_diff);
    since     = s1_now - last_report_time;

    temp_over = temp_mag > {{(TEMP_W+1-TTHR_W){1'b0}}, temp_deadband};
    hum_over  = hum_mag > {{(HUM_W+1-HTHR_W){1'b0}}, hum_deadband};
    // The heartbeat only fires when neither channel crossed its deadband.
    beat      = !temp_over && !hum_over
             && (since >= {{(TIME_W-HB_MS_W){1'b0}}, heartbeat_ms});
    rep_t     = temp_over || beat;
    rep_h     = hum_over || beat;

    last_temperature_next = rep_t ? s1_temperature : last_temperature;
    last_humidity_next    = rep_h ? s1_humidity : last_humidity;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_deadband <= TEMP_DEADBAND_RST;
      hum_deadband  <= HUM_DEADBAND_RST;
      heartbeat_ms  <= HEARTBEAT_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP_DEADBAND:     temp_deadband <= cfg_data[TTHR_W-1:0];
        CFG_HUM_DEADBAND:      hum_deadband  <= cfg_data[HTHR_W-1:0];
        CFG_HEARTBEAT_SECONDS: heartbeat_ms  <= {{(HB_MS_W-HBS_W){1'b0}}, cfg_data}
                                              * {{(HB_MS_W-HBS_W){1'b0}}, MS_PER_SECOND};
        default: ;
      endcase
    end
  end

  // Control and reference state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      last_temperature <= TEMP_START;
      last_humidity    <= HUM_START;
      last_report_time <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid        <= 1'b1;
        last_temperature <= last_temperature_next;
        last_humidity    <= last_humidity_next;
        if (rep_t || rep_h) begin
          last_report_time <= s1_now;
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_temperature <= s_axis_tdata[TEMP_W-1:0];
      s1_humidity    <= s_axis_tdata[TEMP_W+HUM_W-1:TEMP_W];
      s1_now         <= s_axis_tdata[TEMP_W+HUM_W+TIME_W-1:TEMP_W+HUM_W];
    end
    if (advance) begin
      out_report_temperature   <= rep_t;
      out_report_humidity      <= rep_h;
      out_is_heartbeat         <= beat;
      out_reported_temperature <= last_temperature_next;
      out_reported_humidity    <= last_humidity_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reported_humidity, out_reported_temperature,
                          out_report_humidity, out_report_temperature};
  assign m_axis_tuser  = out_is_heartbeat;

  // A heartbeat always reports both channels.
  `ASSERT_CLK(a_beat_reports_both, clk, rst,
    out_valid && out_is_heartbeat |-> out_report_temperature && out_report_humidity)
  // A waiting result always agrees with the stored reference values.
  `ASSERT_CLK(a_out_matches_state, clk, rst,
    out_valid |-> out_reported_temperature == last_temperature
                  && out_reported_humidity == last_humidity)
  // Any report moves the reference time to the sample's timestamp.
  `ASSERT_CLK(a_report_sets_time, clk, rst,
    advance && (rep_t || rep_h) |=> last_report_time == $past(s1_now))
  // A sample without a report leaves the reference state untouched.
  `ASSERT_CLK(a_quiet_keeps_state, clk, rst,
    advance && !rep_t && !rep_h |=> $stable(last_report_time)
                                    && $stable(last_temperature)
                                    && $stable(last_humidity))

endmodule
